>>> hw/rtl/otse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package otse_pkg;

  localparam int TICKER_COUNT      = 4;
  localparam int ORDERS_PER_TICKER = 8;
  localparam int SLOT_COUNT        = TICKER_COUNT * ORDERS_PER_TICKER;
  localparam int SLOT_W            = $clog2(SLOT_COUNT);
  localparam int QUEUE_DEPTH       = 2;
  localparam int QPTR_W            = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W            = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    U_ADD    = 2'd0,
    U_MODIFY = 2'd1,
    U_CANCEL = 2'd2,
    U_OTHER  = 2'd3
  } upd_t;

  typedef enum logic [2:0] {
    K_STATUS = 3'd0,
    K_START  = 3'd1,
    K_CLEAR  = 3'd2,
    K_ADD    = 3'd3,
    K_END    = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    S_OK      = 3'd0,
    S_PRESENT = 3'd1,
    S_MISSING = 3'd2,
    S_SIDE    = 3'd3,
    S_GAP     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_START,
    ST_CLEAR,
    ST_SCAN,
    ST_ADD,
    ST_END
  } state_t;

  // Classified command handed from the front to the executor
  typedef struct packed {
    logic               snap;
    upd_t               typ;
    logic               inrange;
    logic [SLOT_W-1:0]  slot;
    logic               side;
    logic signed [31:0] price;
    logic [31:0]        qty;
    logic [31:0]        priority_req;
    logic [31:0]        seq_num;
  } cmd_t;

  typedef struct packed {
    logic               side;
    logic signed [31:0] price;
    logic [31:0]        qty;
    logic [31:0]        priority_val;
  } entry_t;

  typedef struct packed {
    kind_t              kind;
    status_t            status;
    logic [5:0]         record_seq;
    logic [1:0]         ticker;
    logic [2:0]         order_index;
    logic               side;
    logic signed [31:0] price;
    logic [31:0]        qty;
    logic [31:0]        priority_val;
    logic [31:0]        inc_seq;
    logic               last;
  } rec_t;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [1:0] t, input logic [2:0] o);
    return SLOT_W'((32'(t) * ORDERS_PER_TICKER) + 32'(o));
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/order_table_snapshot_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Order table with snapshot readout. Items enter through a two-deep command
// queue, so a new item is taken while the executor works and while a result
// waits on the output register. Each incremental update first reads the
// addressed slot from the table memory (registered read), then checks it,
// writes it back and presents the status. A snapshot pops the command, emits
// the start record and a clear record per ticker, scans each slot and reads
// each live order from the table (registered read) for its add record, then
// emits the end record. The live flags are cleared by reset, so no clearing
// pass is needed. Results stall only when the output is not popped.
module order_table_snapshot_engine (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output      logic               full,
  input  wire logic               op,
  input  wire logic [1:0]         upd_type,
  input  wire logic [1:0]         ticker,
  input  wire logic [2:0]         order_index,
  input  wire logic               side,
  input  wire logic signed [31:0] price,
  input  wire logic [31:0]        qty,
  input  wire logic [31:0]        priority_req,
  input  wire logic [31:0]        seq_num,
  output      logic               empty,
  input  wire logic               pop,
  output      logic [2:0]         kind,
  output      logic [2:0]         status,
  output      logic [5:0]         record_seq,
  output      logic [1:0]         out_ticker,
  output      logic [2:0]         out_order_index,
  output      logic               out_side,
  output      logic signed [31:0] out_price,
  output      logic [31:0]        out_qty,
  output      logic [31:0]        out_priority,
  output      logic [31:0]        inc_seq,
  output      logic               last
);

  logic           q_wr;
  logic           q_rd;
  logic           q_not_empty;
  otse_pkg::cmd_t q_in;
  otse_pkg::cmd_t q_out;
  logic           out_valid;
  otse_pkg::rec_t out_rec;

  otse_front u_front (
    .push         (push),
    .q_full       (full),
    .op           (op),
    .upd_type     (upd_type),
    .ticker       (ticker),
    .order_index  (order_index),
    .side         (side),
    .price        (price),
    .qty          (qty),
    .priority_req (priority_req),
    .seq_num      (seq_num),
    .q_wr         (q_wr),
    .cmd          (q_in)
  );

  otse_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (q_wr),
    .wr_data   (q_in),
    .full      (full),
    .rd_en     (q_rd),
    .rd_data   (q_out),
    .not_empty (q_not_empty)
  );

  otse_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_not_empty),
    .cmd_head  (q_out),
    .cmd_pop   (q_rd),
    .out_pop   (pop && out_valid),
    .out_valid (out_valid),
    .out_rec   (out_rec)
  );

  assign empty           = !out_valid;
  assign kind            = out_rec.kind;
  assign status          = out_rec.status;
  assign record_seq      = out_rec.record_seq;
  assign out_ticker      = out_rec.ticker;
  assign out_order_index = out_rec.order_index;
  assign out_side        = out_rec.side;
  assign out_price       = out_rec.price;
  assign out_qty         = out_rec.qty;
  assign out_priority    = out_rec.priority_val;
  assign inc_seq         = out_rec.inc_seq;
  assign last            = out_rec.last;

  a_status_only_upd: assert property (@(posedge clk) disable iff (rst)
    !empty && kind != otse_pkg::K_STATUS |-> status == otse_pkg::S_OK)
    else $error("non-zero status on a snapshot record");

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    !empty && last |-> kind == otse_pkg::K_STATUS || kind == otse_pkg::K_END)
    else $error("last marked on a record that does not close a transaction");

  a_start_seq: assert property (@(posedge clk) disable iff (rst)
    !empty && kind == otse_pkg::K_START |-> record_seq == 6'd0 && !last)
    else $error("snapshot start record misnumbered");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    !empty && kind == otse_pkg::K_END |-> last && record_seq != 6'd0)
    else $error("snapshot end record not marked last");

endmodule

`default_nettype wire

>>> hw/rtl/otse_front.sv
`timescale 1ns / 1ps
`default_nettype none

module otse_front (
  input  wire logic               push,
  input  wire logic               q_full,
  input  wire logic               op,
  input  wire logic [1:0]         upd_type,
  input  wire logic [1:0]         ticker,
  input  wire logic [2:0]         order_index,
  input  wire logic               side,
  input  wire logic signed [31:0] price,
  input  wire logic [31:0]        qty,
  input  wire logic [31:0]        priority_req,
  input  wire logic [31:0]        seq_num,
  output      logic               q_wr,
  output      otse_pkg::cmd_t     cmd
);

  logic inrange;

  assign inrange = (32'(ticker) < otse_pkg::TICKER_COUNT) &&
                   (32'(order_index) < otse_pkg::ORDERS_PER_TICKER);

  assign q_wr = push && !q_full;

  always_comb begin
    cmd.snap         = op;
    cmd.typ          = otse_pkg::upd_t'(upd_type);
    cmd.inrange      = inrange;
    cmd.slot         = inrange ? otse_pkg::slot_of(ticker, order_index) : '0;
    cmd.side         = side;
    cmd.price        = price;
    cmd.qty          = qty;
    cmd.priority_req = priority_req;
    cmd.seq_num      = seq_num;
  end

endmodule

`default_nettype wire

>>> hw/rtl/otse_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module otse_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr_en,
  input  wire otse_pkg::cmd_t wr_data,
  output      logic           full,
  input  wire logic           rd_en,
  output      otse_pkg::cmd_t rd_data,
  output      logic           not_empty
);

  otse_pkg::cmd_t                    slots [otse_pkg::QUEUE_DEPTH];
  logic [otse_pkg::QPTR_W-1:0]       wr_ptr;
  logic [otse_pkg::QPTR_W-1:0]       rd_ptr;
  logic [otse_pkg::QCNT_W-1:0]       count;

  assign full      = (count == otse_pkg::QCNT_W'(otse_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign rd_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == otse_pkg::QPTR_W'(otse_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == otse_pkg::QPTR_W'(otse_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/otse_back.sv
`timescale 1ns / 1ps
`default_nettype none

module otse_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  input  wire otse_pkg::cmd_t cmd_head,
  output      logic           cmd_pop,
  input  wire logic           out_pop,
  output      logic           out_valid,
  output      otse_pkg::rec_t out_rec
);

  localparam int SW = otse_pkg::SLOT_W;

  otse_pkg::state_t  state, state_next;
  otse_pkg::cmd_t    cmd;
  logic [1:0]        t, t_next;
  logic [2:0]        o, o_next;
  logic [5:0]        rs, rs_next;
  logic [31:0]       last_seq;
  logic [otse_pkg::SLOT_COUNT-1:0] valid;

  otse_pkg::entry_t  mem [otse_pkg::SLOT_COUNT];
  otse_pkg::entry_t  mem_q;
  logic              mem_re, mem_we;
  logic [SW-1:0]     mem_ra;
  otse_pkg::entry_t  mem_wd;

  logic              out_free;
  logic              emit;
  otse_pkg::rec_t    emit_rec;
  logic              valid_set, valid_clr, seq_take;
  logic [SW-1:0]     scan_slot;
  logic              o_last, t_last;

  otse_pkg::status_t upd_status;
  logic              upd_add, upd_mod, upd_cancel;

  assign out_free  = !out_valid || out_pop;
  assign scan_slot = otse_pkg::slot_of(t, o);
  assign o_last    = (o == 3'(otse_pkg::ORDERS_PER_TICKER - 1));
  assign t_last    = (t == 2'(otse_pkg::TICKER_COUNT - 1));

  // Entry checks first, then the sequence check
  always_comb begin
    upd_status = otse_pkg::S_OK;
    upd_add    = 1'b0;
    upd_mod    = 1'b0;
    upd_cancel = 1'b0;
    if (cmd.typ != otse_pkg::U_OTHER) begin
      if (!cmd.inrange) begin
        upd_status = otse_pkg::S_MISSING;
      end else if (cmd.typ == otse_pkg::U_ADD) begin
        if (valid[cmd.slot]) begin
          upd_status = otse_pkg::S_PRESENT;
        end else begin
          upd_add = 1'b1;
        end
      end else if (!valid[cmd.slot]) begin
        upd_status = otse_pkg::S_MISSING;
      end else if (mem_q.side != cmd.side) begin
        upd_status = otse_pkg::S_SIDE;
      end else if (cmd.typ == otse_pkg::U_MODIFY) begin
        upd_mod = 1'b1;
      end else begin
        upd_cancel = 1'b1;
      end
    end
    if (upd_status == otse_pkg::S_OK && cmd.seq_num != last_seq + 32'd1) begin
      upd_status = otse_pkg::S_GAP;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      otse_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          state_next = cmd_head.snap ? otse_pkg::ST_START : otse_pkg::ST_UPD;
        end
      end
      otse_pkg::ST_UPD: begin
        if (out_free) state_next = otse_pkg::ST_IDLE;
      end
      otse_pkg::ST_START: begin
        if (out_free) state_next = otse_pkg::ST_CLEAR;
      end
      otse_pkg::ST_CLEAR: begin
        if (out_free) state_next = otse_pkg::ST_SCAN;
      end
      otse_pkg::ST_SCAN: begin
        if (valid[scan_slot]) begin
          state_next = otse_pkg::ST_ADD;
        end else if (o_last) begin
          state_next = t_last ? otse_pkg::ST_END : otse_pkg::ST_CLEAR;
        end
      end
      otse_pkg::ST_ADD: begin
        if (out_free) begin
          if (!o_last) begin
            state_next = otse_pkg::ST_SCAN;
          end else begin
            state_next = t_last ? otse_pkg::ST_END : otse_pkg::ST_CLEAR;
          end
        end
      end
      otse_pkg::ST_END: begin
        if (out_free) state_next = otse_pkg::ST_IDLE;
      end
      default: state_next = otse_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop   = 1'b0;
    emit      = 1'b0;
    emit_rec  = '0;
    mem_re    = 1'b0;
    mem_ra    = cmd_head.slot;
    mem_we    = 1'b0;
    mem_wd    = mem_q;
    valid_set = 1'b0;
    valid_clr = 1'b0;
    seq_take  = 1'b0;
    t_next    = t;
    o_next    = o;
    rs_next   = rs;
    unique case (state)
      otse_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          mem_re  = !cmd_head.snap;
        end
      end
      otse_pkg::ST_UPD: begin
        if (out_free) begin
          emit            = 1'b1;
          emit_rec.kind   = otse_pkg::K_STATUS;
          emit_rec.status = upd_status;
          emit_rec.last   = 1'b1;
          seq_take        = 1'b1;
          mem_we          = upd_add || upd_mod;
          mem_wd.side     = upd_add ? cmd.side : mem_q.side;
          mem_wd.price    = cmd.price;
          mem_wd.qty      = cmd.qty;
          mem_wd.priority_val = upd_add ? cmd.priority_req : mem_q.priority_val;
          valid_set       = upd_add;
          valid_clr       = upd_cancel;
        end
      end
      otse_pkg::ST_START: begin
        if (out_free) begin
          emit                = 1'b1;
          emit_rec.kind       = otse_pkg::K_START;
          emit_rec.record_seq = '0;
          emit_rec.inc_seq    = last_seq;
          rs_next             = 6'd1;
          t_next              = '0;
        end
      end
      otse_pkg::ST_CLEAR: begin
        if (out_free) begin
          emit                = 1'b1;
          emit_rec.kind       = otse_pkg::K_CLEAR;
          emit_rec.record_seq = rs;
          emit_rec.ticker     = t;
          rs_next             = rs + 6'd1;
          o_next              = '0;
        end
      end
      otse_pkg::ST_SCAN: begin
        mem_ra = scan_slot;
        if (valid[scan_slot]) begin
          mem_re = 1'b1;
        end else if (!o_last) begin
          o_next = o + 3'd1;
        end else if (!t_last) begin
          t_next = t + 2'd1;
        end
      end
      otse_pkg::ST_ADD: begin
        mem_ra = scan_slot;
        if (out_free) begin
          emit                  = 1'b1;
          emit_rec.kind         = otse_pkg::K_ADD;
          emit_rec.record_seq   = rs;
          emit_rec.ticker       = t;
          emit_rec.order_index  = o;
          emit_rec.side         = mem_q.side;
          emit_rec.price        = mem_q.price;
          emit_rec.qty          = mem_q.qty;
          emit_rec.priority_val = mem_q.priority_val;
          rs_next               = rs + 6'd1;
          if (!o_last) begin
            o_next = o + 3'd1;
          end else if (!t_last) begin
            t_next = t + 2'd1;
          end
        end
      end
      otse_pkg::ST_END: begin
        if (out_free) begin
          emit                = 1'b1;
          emit_rec.kind       = otse_pkg::K_END;
          emit_rec.record_seq = rs;
          emit_rec.inc_seq    = last_seq;
          emit_rec.last       = 1'b1;
        end
      end
      default: begin
        cmd_pop = 1'b0;
      end
    endcase
  end

  // Table payload: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cmd.slot] <= mem_wd;
    end
    if (mem_re) begin
      mem_q <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd <= cmd_head;
    end
    if (emit) begin
      out_rec <= emit_rec;
    end
    t  <= t_next;
    o  <= o_next;
    rs <= rs_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= otse_pkg::ST_IDLE;
      valid     <= '0;
      last_seq  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (valid_set) begin
        valid[cmd.slot] <= 1'b1;
      end else if (valid_clr) begin
        valid[cmd.slot] <= 1'b0;
      end
      if (seq_take) begin
        last_seq <= cmd.seq_num;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> sim/order_table_snapshot_engine_tb.sv
`timescale 1ns / 1ps

module order_table_snapshot_engine_tb;
  import otse_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int RANDOM_ITEMS = 375;

  typedef struct packed {
    logic        op;
    upd_t        typ;
    logic [1:0]  tick;
    logic [2:0]  oidx;
    logic        sd;
    logic [31:0] price;
    logic [31:0] qty;
    logic [31:0] prio;
    logic [31:0] seq;
  } txn_t;

  typedef struct {
    txn_t    t;
    bit      typed;
    status_t st;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic op = 1'b0;
  logic [1:0] upd_type = '0;
  logic [1:0] ticker = '0;
  logic [2:0] order_index = '0;
  logic side = 1'b0;
  logic signed [31:0] price = '0;
  logic [31:0] qty = '0;
  logic [31:0] priority_req = '0;
  logic [31:0] seq_num = '0;
  logic empty;
  logic pop = 1'b0;
  logic [2:0] kind;
  logic [2:0] status;
  logic [5:0] record_seq;
  logic [1:0] out_ticker;
  logic [2:0] out_order_index;
  logic out_side;
  logic signed [31:0] out_price;
  logic [31:0] out_qty;
  logic [31:0] out_priority;
  logic [31:0] inc_seq;
  logic last;

  order_table_snapshot_engine dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .op(op), .upd_type(upd_type),
    .ticker(ticker), .order_index(order_index), .side(side), .price(price), .qty(qty),
    .priority_req(priority_req), .seq_num(seq_num), .empty(empty), .pop(pop),
    .kind(kind), .status(status), .record_seq(record_seq), .out_ticker(out_ticker),
    .out_order_index(out_order_index), .out_side(out_side), .out_price(out_price),
    .out_qty(out_qty), .out_priority(out_priority), .inc_seq(inc_seq), .last(last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow order book
  bit          book_live [SLOT_COUNT];
  logic        book_side [SLOT_COUNT];
  logic [31:0] book_price [SLOT_COUNT];
  logic [31:0] book_qty [SLOT_COUNT];
  logic [31:0] book_prio [SLOT_COUNT];
  logic [31:0] book_seq = '0;

  rec_t pending_recs[$];
  row_t dir_rows[$];
  int   errors = 0;
  int   sent = 0;
  int   popped = 0;
  int   stall_left = 0;
  int   quiet_cycles = 0;

  // Apply one transaction to the shadow book and queue the records it yields
  function automatic void book_apply(input txn_t t);
    rec_t    r;
    int      rs;
    int      s;
    bit      inrange;
    status_t st;
    if (t.op) begin
      rs = 0;
      r = '0;
      r.kind = K_START;
      r.record_seq = 6'(rs++);
      r.inc_seq = book_seq;
      pending_recs.push_back(r);
      for (int tk = 0; tk < TICKER_COUNT; tk++) begin
        r = '0;
        r.kind = K_CLEAR;
        r.record_seq = 6'(rs++);
        r.ticker = 2'(tk);
        pending_recs.push_back(r);
        for (int o = 0; o < ORDERS_PER_TICKER; o++) begin
          s = tk * ORDERS_PER_TICKER + o;
          if (book_live[s]) begin
            r = '0;
            r.kind = K_ADD;
            r.record_seq = 6'(rs++);
            r.ticker = 2'(tk);
            r.order_index = 3'(o);
            r.side = book_side[s];
            r.price = book_price[s];
            r.qty = book_qty[s];
            r.priority_val = book_prio[s];
            pending_recs.push_back(r);
          end
        end
      end
      r = '0;
      r.kind = K_END;
      r.record_seq = 6'(rs);
      r.inc_seq = book_seq;
      r.last = 1'b1;
      pending_recs.push_back(r);
    end else begin
      st = S_OK;
      inrange = (int'(t.tick) < TICKER_COUNT) && (int'(t.oidx) < ORDERS_PER_TICKER);
      s = inrange ? int'(t.tick) * ORDERS_PER_TICKER + int'(t.oidx) : 0;
      if (t.typ != U_OTHER) begin
        if (!inrange) begin
          st = S_MISSING;
        end else if (t.typ == U_ADD) begin
          if (book_live[s]) begin
            st = S_PRESENT;
          end else begin
            book_live[s] = 1'b1;
            book_side[s] = t.sd;
            book_price[s] = t.price;
            book_qty[s] = t.qty;
            book_prio[s] = t.prio;
          end
        end else if (!book_live[s]) begin
          st = S_MISSING;
        end else if (book_side[s] != t.sd) begin
          st = S_SIDE;
        end else if (t.typ == U_MODIFY) begin
          book_qty[s] = t.qty;
          book_price[s] = t.price;
        end else begin
          book_live[s] = 1'b0;
        end
      end
      if (st == S_OK && t.seq != book_seq + 32'd1) st = S_GAP;
      book_seq = t.seq;
      r = '0;
      r.kind = K_STATUS;
      r.status = st;
      r.last = 1'b1;
      pending_recs.push_back(r);
    end
  endfunction

  function automatic int pick_gap(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mostly random words, with the extremes now and then
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 11))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic txn_t any_txn();
    txn_t t;
    t.op = 1'($urandom);
    t.typ = upd_t'($urandom_range(0, 3));
    t.tick = 2'($urandom);
    t.oidx = 3'($urandom);
    t.sd = 1'($urandom);
    t.price = pick_word();
    t.qty = pick_word();
    t.prio = pick_word();
    t.seq = $urandom;
    return t;
  endfunction

  function automatic txn_t snap_txn();
    txn_t t;
    t = any_txn();
    t.op = 1'b1;
    return t;
  endfunction

  function automatic row_t upd_row(input upd_t typ, input int tk, input int o, input bit sd,
                                   input logic [31:0] pr, input logic [31:0] q,
                                   input logic [31:0] pq, input logic [31:0] sq,
                                   input status_t st);
    row_t r;
    r.t = '{op: 1'b0, typ: typ, tick: 2'(tk), oidx: 3'(o), sd: sd, price: pr, qty: q,
            prio: pq, seq: sq};
    r.typed = 1'b1;
    r.st = st;
    return r;
  endfunction

  function automatic row_t snap_row();
    row_t r;
    r.t = snap_txn();
    r.typed = 1'b0;
    r.st = S_OK;
    return r;
  endfunction

  // Well-formed traffic against the current book, with some broken updates mixed in
  function automatic txn_t pick_update();
    txn_t t;
    int   s;
    int   r;
    t = any_txn();
    t.op = 1'b0;
    s = int'(t.tick) * ORDERS_PER_TICKER + int'(t.oidx);
    r = $urandom_range(0, 99);
    if (book_live[s]) begin
      if (r < 10) t.typ = U_ADD;
      else if (r < 55) t.typ = U_MODIFY;
      else if (r < 90) t.typ = U_CANCEL;
      else t.typ = U_OTHER;
      t.sd = ($urandom_range(0, 9) == 0) ? !book_side[s] : book_side[s];
    end else begin
      if (r < 75) t.typ = U_ADD;
      else if (r < 80) t.typ = U_MODIFY;
      else if (r < 85) t.typ = U_CANCEL;
      else t.typ = U_OTHER;
    end
    r = $urandom_range(0, 99);
    if (r < 85) t.seq = book_seq + 32'd1;
    else if (r < 90) t.seq = book_seq;
    else if (r < 95) t.seq = $urandom;
    else t.seq = ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hffff_ffff;
    return t;
  endfunction

  task automatic send(input txn_t t, input bit typed, input status_t st);
    int n;
    push <= 1'b1;
    op <= t.op;
    upd_type <= t.typ;
    ticker <= t.tick;
    order_index <= t.oidx;
    side <= t.sd;
    price <= t.price;
    qty <= t.qty;
    priority_req <= t.prio;
    seq_num <= t.seq;
    do @(posedge clk); while (full);
    book_apply(t);
    if (typed) pending_recs[$].status = st;
    sent++;
    n = pick_gap(((sent / 40) % 3) == 2);
    if (n > 0) begin
      push <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s expected %0h got %0h", $time, name, e, a);
      errors++;
    end
  endtask

  // Result side: check each popped transaction, then decide on the next stall
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      stall_left = 0;
    end else begin
      if (pop && !empty) begin
        popped++;
        if (pending_recs.size() == 0) begin
          $display("%0t: unexpected result kind %0d", $time, kind);
          errors++;
        end else begin
          check_field("kind", pending_recs[0].kind, kind);
          check_field("status", pending_recs[0].status, status);
          check_field("record_seq", pending_recs[0].record_seq, record_seq);
          check_field("out_ticker", pending_recs[0].ticker, out_ticker);
          check_field("out_order_index", pending_recs[0].order_index, out_order_index);
          check_field("out_side", pending_recs[0].side, out_side);
          check_field("out_price", pending_recs[0].price, out_price);
          check_field("out_qty", pending_recs[0].qty, out_qty);
          check_field("out_priority", pending_recs[0].priority_val, out_priority);
          check_field("inc_seq", pending_recs[0].inc_seq, inc_seq);
          check_field("last", pending_recs[0].last, last);
          void'(pending_recs.pop_front());
        end
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
        stall_left = pick_gap(((popped / 60) % 3) == 1);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    txn_t t;
    for (int s = 0; s < SLOT_COUNT; s++) book_live[s] = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    dir_rows.push_back(snap_row());
    dir_rows.push_back(upd_row(U_ADD, 0, 0, 0, 32'h8000_0000, 32'h0, 32'h0, 32'd1, S_OK));
    dir_rows.push_back(upd_row(U_ADD, 3, 7, 1, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                               32'd2, S_OK));
    dir_rows.push_back(upd_row(U_ADD, 0, 0, 1, 32'h5, 32'h6, 32'h7, 32'd3, S_PRESENT));
    dir_rows.push_back(upd_row(U_MODIFY, 1, 2, 0, 32'h1, 32'h1, 32'h1, 32'd4, S_MISSING));
    dir_rows.push_back(upd_row(U_CANCEL, 2, 5, 1, 32'h1, 32'h1, 32'h1, 32'd5, S_MISSING));
    dir_rows.push_back(upd_row(U_MODIFY, 3, 7, 0, 32'h1, 32'h1, 32'h1, 32'd6, S_SIDE));
    dir_rows.push_back(upd_row(U_CANCEL, 0, 0, 1, 32'h1, 32'h1, 32'h1, 32'd7, S_SIDE));
    dir_rows.push_back(upd_row(U_MODIFY, 3, 7, 1, 32'hffff_ffff, 32'd5, 32'h0, 32'd8, S_OK));
    dir_rows.push_back(upd_row(U_OTHER, 2, 2, 0, 32'h0, 32'h0, 32'h0, 32'd9, S_OK));
    dir_rows.push_back(upd_row(U_OTHER, 1, 6, 1, 32'h0, 32'h0, 32'h0, 32'd20, S_GAP));
    // A gap still applies the add
    dir_rows.push_back(upd_row(U_ADD, 1, 3, 1, 32'h1234, 32'h55, 32'h66, 32'd0, S_GAP));
    dir_rows.push_back(upd_row(U_ADD, 1, 3, 0, 32'h1, 32'h1, 32'h1, 32'd100, S_PRESENT));
    dir_rows.push_back(snap_row());
    dir_rows.push_back(upd_row(U_CANCEL, 1, 3, 1, 32'h0, 32'h0, 32'h0, 32'd101, S_OK));
    dir_rows.push_back(upd_row(U_CANCEL, 3, 7, 1, 32'h0, 32'h0, 32'h0, 32'd102, S_OK));
    dir_rows.push_back(upd_row(U_OTHER, 0, 0, 0, 32'h0, 32'h0, 32'h0, 32'hffff_ffff, S_GAP));
    // Sequence wraps from all ones to zero
    dir_rows.push_back(upd_row(U_OTHER, 3, 7, 1, 32'h0, 32'h0, 32'h0, 32'd0, S_OK));
    dir_rows.push_back(upd_row(U_ADD, 2, 4, 0, 32'hffff_fff0, 32'd9, 32'h8000_0000, 32'd1,
                               S_OK));
    dir_rows.push_back(snap_row());
    dir_rows.push_back(upd_row(U_CANCEL, 0, 0, 0, 32'h0, 32'h0, 32'h0, 32'd2, S_OK));
    dir_rows.push_back(upd_row(U_CANCEL, 2, 4, 0, 32'h0, 32'h0, 32'h0, 32'd3, S_OK));

    foreach (dir_rows[i]) send(dir_rows[i].t, dir_rows[i].typed, dir_rows[i].st);

    // Fill every slot, then read out the longest snapshot
    for (int s = 0; s < SLOT_COUNT; s++) begin
      t = any_txn();
      t.op = 1'b0;
      t.typ = U_ADD;
      t.tick = 2'(s / ORDERS_PER_TICKER);
      t.oidx = 3'(s % ORDERS_PER_TICKER);
      t.seq = book_seq + 32'd1;
      send(t, 1'b0, S_OK);
    end
    send(snap_txn(), 1'b0, S_OK);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 99) < 4) t = snap_txn();
      else t = pick_update();
      send(t, 1'b0, S_OK);
    end
    push <= 1'b0;

    while (pending_recs.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/otse_pkg.sv
hw/rtl/otse_front.sv
hw/rtl/otse_queue.sv
hw/rtl/otse_back.sv
hw/rtl/order_table_snapshot_engine.sv
sim/order_table_snapshot_engine_tb.sv
